// ===== hdl/hdl_source_lexer_unit_macros.svh =====
// Assertion macros for the source lexer.
`ifndef HDL_SOURCE_LEXER_UNIT_MACROS_SVH
`define HDL_SOURCE_LEXER_UNIT_MACROS_SVH

// same-cycle implication
`define HSLEX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HSLEX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/hslex_pkg.sv =====
// Package for the source lexer: codes, lexer states and character classes.
`default_nettype none

package hslex_pkg;

	localparam int DefOffsetBits = 32;
	localparam int DefValueBits  = 64;

	localparam logic [7:0] CharHigh       = 8'h80;
	localparam logic [7:0] CharUnderscore = 8'h5F;
	localparam logic [7:0] CharZero       = 8'h30;
	localparam logic [5:0] DigitNone      = 6'd36;

	typedef enum logic [3:0] {
		TK_LINE  = 4'd0,
		TK_BLOCK = 4'd1,
		TK_SLASH = 4'd2,
		TK_IDENT = 4'd3,
		TK_PLAIN = 4'd4,
		TK_DEC   = 4'd5,
		TK_HEX   = 4'd6,
		TK_OCT   = 4'd7,
		TK_BIN   = 4'd8,
		TK_END   = 4'd9,
		TK_ERR   = 4'd10
	} token_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_OPEN_BLOCK = 3'd1,
		ERR_LEAD_ZERO  = 3'd2,
		ERR_DIGIT_BIG  = 3'd3,
		ERR_NO_DIGITS  = 3'd4,
		ERR_ILLEGAL    = 3'd5
	} err_code_t;

	typedef enum logic [3:0] {
		LM_IDLE       = 4'd0,
		LM_SLASH      = 4'd1,
		LM_LINE       = 4'd2,
		LM_BLOCK      = 4'd3,
		LM_BLOCK_STAR = 4'd4,
		LM_IDENT      = 4'd5,
		LM_ZERO       = 4'd6,
		LM_DIGITS     = 4'd7,
		LM_ERROR      = 4'd8
	} lex_mode_t;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	function automatic logic is_space(input logic [7:0] b);
		return b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A;
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic is_dec(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_name_start(input logic [7:0] b);
		return b >= CharHigh || is_letter(b) || b == CharUnderscore;
	endfunction

	// value 0..35, DigitNone for anything else
	function automatic logic [5:0] digit_of(input logic [7:0] b);
		logic [7:0] t;
		t = 8'd0;
		if (is_dec(b)) begin
			t = b - CharZero;
		end else if (b >= "a" && b <= "z") begin
			t = b - "a" + 8'd10;
		end else if (b >= "A" && b <= "Z") begin
			t = b - "A" + 8'd10;
		end else begin
			t = {2'b00, DigitNone};
		end
		return t[5:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/hdl_source_lexer_unit.sv =====
// Streaming lexer: source bytes in, tokens with offsets and literal values out.
//
// Input channel (src_valid/src_stall): one word per byte, kind = 0, or an
// end-of-input mark, kind = 1. Output channel (tok_valid/tok_stall): one token
// word per handshake; a byte causes zero, one or two tokens, last_of_run marks
// the final one of each byte.
// An accepted byte waits in the input register until it advances, which writes
// its tokens into the queue. Throughput: one byte per cycle while the output side
// keeps up; a byte that yields two tokens hands them out one per handshake.
// The single lexer step between input register and four-entry queue sets the rate.
// src_stall rises when the queue has fewer than two free slots with a byte
// waiting in the input register; while it is high no byte advances and the
// queue only drains.
// A stalled receiver only backs up the queue; no token is dropped.
// Reset clears the lexer state, offset counter and queue; tok_valid is low.
// End of input emits any pending token, then an end token, and returns the
// offset counter to zero.
`default_nettype none

module hdl_source_lexer_unit
	import hslex_pkg::*;
#(
	parameter int OFFSET_BITS = DefOffsetBits,
	parameter int VALUE_BITS  = DefValueBits
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   src_valid,
	output logic                        src_stall,
	input  wire logic                   kind,
	input  wire logic [7:0]             byte_value,

	output logic                        tok_valid,
	input  wire logic                   tok_stall,
	output logic [3:0]                  token_kind,
	output logic [2:0]                  error_code,
	output logic [OFFSET_BITS-1:0]      start_offset,
	output logic [OFFSET_BITS-1:0]      end_offset,
	output logic [VALUE_BITS-1:0]       literal_value,
	output logic                        value_overflow,
	output logic                        last_of_run
);

	localparam int FifoDepth = 4;
	localparam int PtrBits   = $clog2(FifoDepth);
	localparam int CntBits   = $clog2(FifoDepth + 1);
	localparam int ExtBits   = VALUE_BITS + 4;

	typedef struct packed {
		token_kind_t            kind;
		err_code_t              err;
		logic [OFFSET_BITS-1:0] s;
		logic [OFFSET_BITS-1:0] e;
		logic [VALUE_BITS-1:0]  val;
		logic                   ov;
		logic                   last;
	} res_t;

	function automatic res_t mk_res(input token_kind_t k, input err_code_t c,
			input logic [OFFSET_BITS-1:0] s, input logic [OFFSET_BITS-1:0] e,
			input logic [VALUE_BITS-1:0] v, input logic o);
		res_t r;
		r.kind = k;
		r.err  = c;
		r.s    = s;
		r.e    = e;
		r.val  = v;
		r.ov   = o;
		r.last = 1'b0;
		return r;
	endfunction

	// input register
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;

	// lexer state
	lex_mode_t              mode_q, mode_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [OFFSET_BITS-1:0] ts_q, ts_d;
	token_kind_t            ntype_q, ntype_d;
	logic                   have_q, have_d;
	logic [VALUE_BITS-1:0]  acc_q, acc_d;
	logic                   ov_q, ov_d;

	// token queue
	res_t               fifo_q [FifoDepth];
	logic [PtrBits-1:0] wr_q, rd_q;
	logic [CntBits-1:0] cnt_q;

	logic room, advance, pop;

	assign room      = cnt_q <= CntBits'(FifoDepth - 2);
	assign advance   = valid_s1 && room;
	assign src_stall = valid_s1 && !room;
	assign pop       = tok_valid && !tok_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			kind_s1 <= kind;
			byte_s1 <= byte_value;
		end
	end

	// digit and accumulate
	logic [4:0]         base_v;
	logic [5:0]         dig_v;
	logic [ExtBits-1:0] ext_v, prod_v, sum_v;
	logic               acc_over;

	always_comb begin
		case (ntype_q)
			TK_BIN:  base_v = 5'd2;
			TK_OCT:  base_v = 5'd8;
			TK_HEX:  base_v = 5'd16;
			default: base_v = 5'd10;
		endcase
		dig_v = digit_of(byte_s1);
		ext_v = {4'b0000, acc_q};
		case (ntype_q)
			TK_BIN:  prod_v = ext_v << 1;
			TK_OCT:  prod_v = ext_v << 3;
			TK_HEX:  prod_v = ext_v << 4;
			default: prod_v = (ext_v << 3) + (ext_v << 1);
		endcase
		sum_v    = prod_v + ExtBits'(dig_v);
		acc_over = |sum_v[ExtBits-1:VALUE_BITS];
	end

	// one lexer step: ra is the token the byte closes, rb the idle-step or end token
	res_t ra, rb;
	logic ha, hb;
	logic do_idle;
	logic [OFFSET_BITS-1:0] pos_inc;

	assign pos_inc = pos_q + OFFSET_BITS'(1);

	always_comb begin
		mode_d  = mode_q;
		pos_d   = pos_inc;
		ts_d    = ts_q;
		ntype_d = ntype_q;
		have_d  = have_q;
		acc_d   = acc_q;
		ov_d    = ov_q;
		ra      = mk_res(TK_END, ERR_NONE, '0, '0, '0, 1'b0);
		rb      = ra;
		ha      = 1'b0;
		hb      = 1'b0;
		do_idle = 1'b0;

		if (kind_s1 == KIND_END) begin
			case (mode_q)
				LM_SLASH: begin
					ra = mk_res(TK_SLASH, ERR_NONE, ts_q, pos_q, '0, 1'b0);
					ha = 1'b1;
				end
				LM_LINE: begin
					ra = mk_res(TK_LINE, ERR_NONE, ts_q, pos_q, '0, 1'b0);
					ha = 1'b1;
				end
				LM_BLOCK, LM_BLOCK_STAR: begin
					ra = mk_res(TK_ERR, ERR_OPEN_BLOCK, ts_q, pos_q, '0, 1'b0);
					ha = 1'b1;
				end
				LM_IDENT: begin
					ra = mk_res(TK_IDENT, ERR_NONE, ts_q, pos_q, '0, 1'b0);
					ha = 1'b1;
				end
				LM_ZERO: begin
					ra = mk_res(ntype_q, ERR_NONE, ts_q, pos_q, acc_q, ov_q);
					ha = 1'b1;
				end
				LM_DIGITS: begin
					if (have_q) begin
						ra = mk_res(ntype_q, ERR_NONE, ts_q, pos_q, acc_q, ov_q);
					end else begin
						ra = mk_res(TK_ERR, ERR_NO_DIGITS, pos_q, pos_q, '0, 1'b0);
					end
					ha = 1'b1;
				end
				default: ;
			endcase
			rb      = mk_res(TK_END, ERR_NONE, pos_q, pos_q, '0, 1'b0);
			hb      = 1'b1;
			mode_d  = LM_IDLE;
			pos_d   = '0;
			ts_d    = '0;
			ntype_d = TK_PLAIN;
			have_d  = 1'b0;
			acc_d   = '0;
			ov_d    = 1'b0;
		end else begin
			case (mode_q)
				LM_IDLE: do_idle = 1'b1;
				LM_SLASH: begin
					if (byte_s1 == "/") begin
						mode_d = LM_LINE;
					end else if (byte_s1 == "*") begin
						mode_d = LM_BLOCK;
					end else begin
						ra      = mk_res(TK_SLASH, ERR_NONE, ts_q, pos_q, '0, 1'b0);
						ha      = 1'b1;
						mode_d  = LM_IDLE;
						do_idle = 1'b1;
					end
				end
				LM_LINE: begin
					if (byte_s1 == 8'h0D || byte_s1 == 8'h0A) begin
						ra      = mk_res(TK_LINE, ERR_NONE, ts_q, pos_q, '0, 1'b0);
						ha      = 1'b1;
						mode_d  = LM_IDLE;
						do_idle = 1'b1;
					end
				end
				LM_BLOCK: begin
					if (byte_s1 == "*") begin
						mode_d = LM_BLOCK_STAR;
					end
				end
				LM_BLOCK_STAR: begin
					if (byte_s1 == "/") begin
						ra     = mk_res(TK_BLOCK, ERR_NONE, ts_q, pos_inc, '0, 1'b0);
						ha     = 1'b1;
						mode_d = LM_IDLE;
					end else if (byte_s1 != "*") begin
						mode_d = LM_BLOCK;
					end
				end
				LM_IDENT: begin
					if (!(is_name_start(byte_s1) || is_dec(byte_s1))) begin
						ra      = mk_res(TK_IDENT, ERR_NONE, ts_q, pos_q, '0, 1'b0);
						ha      = 1'b1;
						mode_d  = LM_IDLE;
						do_idle = 1'b1;
					end
				end
				LM_ZERO: begin
					if (byte_s1 == "b" || byte_s1 == "B") begin
						ntype_d = TK_BIN;
					end else if (byte_s1 == "h" || byte_s1 == "H" ||
							byte_s1 == "x" || byte_s1 == "X") begin
						ntype_d = TK_HEX;
					end else if (byte_s1 == "o" || byte_s1 == "O") begin
						ntype_d = TK_OCT;
					end else if (byte_s1 == "d" || byte_s1 == "D") begin
						ntype_d = TK_DEC;
					end
					if (ntype_d != TK_PLAIN) begin
						mode_d = LM_DIGITS;
						have_d = 1'b0;
						acc_d  = '0;
						ov_d   = 1'b0;
					end else if (is_dec(byte_s1)) begin
						ra     = mk_res(TK_ERR, ERR_LEAD_ZERO, pos_q, pos_q, '0, 1'b0);
						ha     = 1'b1;
						mode_d = LM_ERROR;
					end else begin
						ra      = mk_res(ntype_q, ERR_NONE, ts_q, pos_q, acc_q, ov_q);
						ha      = 1'b1;
						mode_d  = LM_IDLE;
						do_idle = 1'b1;
					end
				end
				LM_DIGITS: begin
					if ({1'b0, dig_v} < {2'b00, base_v}) begin
						have_d = 1'b1;
						if (ov_q || acc_over) begin
							ov_d  = 1'b1;
							acc_d = '1;
						end else begin
							acc_d = sum_v[VALUE_BITS-1:0];
						end
					end else if (dig_v < DigitNone) begin
						ra     = mk_res(TK_ERR, ERR_DIGIT_BIG, pos_q, pos_q, '0, 1'b0);
						ha     = 1'b1;
						mode_d = LM_ERROR;
					end else if (!have_q) begin
						ra     = mk_res(TK_ERR, ERR_NO_DIGITS, pos_q, pos_q, '0, 1'b0);
						ha     = 1'b1;
						mode_d = LM_ERROR;
					end else begin
						ra      = mk_res(ntype_q, ERR_NONE, ts_q, pos_q, acc_q, ov_q);
						ha      = 1'b1;
						mode_d  = LM_IDLE;
						do_idle = 1'b1;
					end
				end
				default: mode_d = LM_ERROR;
			endcase

			if (do_idle && !is_space(byte_s1)) begin
				ts_d = pos_q;
				if (byte_s1 == "/") begin
					mode_d = LM_SLASH;
				end else if (is_name_start(byte_s1)) begin
					mode_d = LM_IDENT;
				end else if (is_dec(byte_s1)) begin
					mode_d  = (byte_s1 == CharZero) ? LM_ZERO : LM_DIGITS;
					ntype_d = TK_PLAIN;
					have_d  = 1'b1;
					acc_d   = '0;
					acc_d[3:0] = dig_v[3:0];
					ov_d    = 1'b0;
				end else begin
					rb     = mk_res(TK_ERR, ERR_ILLEGAL, pos_q, pos_q, '0, 1'b0);
					hb     = 1'b1;
					mode_d = LM_ERROR;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= LM_IDLE;
			pos_q   <= '0;
			ts_q    <= '0;
			ntype_q <= TK_PLAIN;
			have_q  <= 1'b0;
			acc_q   <= '0;
			ov_q    <= 1'b0;
		end else if (advance) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			ts_q    <= ts_d;
			ntype_q <= ntype_d;
			have_q  <= have_d;
			acc_q   <= acc_d;
			ov_q    <= ov_d;
		end
	end

	// queue write
	res_t       w0, w1;
	logic [1:0] npush;

	always_comb begin
		npush = 2'(ha) + 2'(hb);
		w0 = ha ? ra : rb;
		w1 = rb;
		w0.last = !(ha && hb);
		w1.last = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (npush != 2'd0) begin
				fifo_q[wr_q] <= w0;
			end
			if (npush == 2'd2) begin
				fifo_q[wr_q + PtrBits'(1)] <= w1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (advance) begin
				wr_q <= wr_q + PtrBits'(npush);
			end
			if (pop) begin
				rd_q <= rd_q + PtrBits'(1);
			end
			cnt_q <= cnt_q + (advance ? CntBits'(npush) : CntBits'(0)) - CntBits'(pop);
		end
	end

	assign tok_valid      = cnt_q != '0;
	assign token_kind     = fifo_q[rd_q].kind;
	assign error_code     = fifo_q[rd_q].err;
	assign start_offset   = fifo_q[rd_q].s;
	assign end_offset     = fifo_q[rd_q].e;
	assign literal_value  = fifo_q[rd_q].val;
	assign value_overflow = fifo_q[rd_q].ov;
	assign last_of_run    = fifo_q[rd_q].last;

	`include "hdl_source_lexer_unit_macros.svh"

	`HSLEX_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CntBits'(FifoDepth), "queue overrun")
	`HSLEX_ASSERT_NEXT(a_s1_hold, clk, arst_n, src_stall, valid_s1 && $stable(byte_s1) && $stable(kind_s1), "held word lost")
	`HSLEX_ASSERT_NEXT(a_end_clears, clk, arst_n, advance && kind_s1 == KIND_END, pos_q == '0 && mode_q == LM_IDLE, "end of input did not clear state")
	`HSLEX_ASSERT_NOW(a_error_quiet, clk, arst_n, advance && mode_q == LM_ERROR && kind_s1 == KIND_BYTE, npush == 2'd0, "token after error")

endmodule

`default_nettype wire
